// ===== rtl/dfs_pkg.sv =====
// Shared types and constants for the descending fitness sorter.
// Holds the input and result item structs and the controller command struct.
// No dependencies.
package dfs_pkg;

    // Field widths fixed by the item format.
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    // Population size register.
    localparam int         CFG_W     = 7;
    localparam logic [6:0] CFG_RESET = 7'd64;

    // Default depth of the sorting chain.
    localparam int POP_SIZE_DEF = 64;

    // One input item: a Q16.16 key and the tag that travels with it.
    typedef struct packed {
        logic signed [KEY_W-1:0] fitness;
        logic        [TAG_W-1:0] individual_tag;
    } t_in_item;

    // One result item of the sorted burst.
    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_fitness;
        logic        [TAG_W-1:0] sorted_tag;
        logic                    last_item;
    } t_out_item;

    // Commands from the controller to the sorting chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_dfs_cmd;

endpackage

// ===== rtl/dfs_chain.sv =====
// Datapath of the descending fitness sorter: a chain of key/tag cells.
// Inserts items in sorted position while loading and shifts toward the head
// while emitting. Depends on dfs_pkg.
module dfs_chain #(
    parameter int POP_SIZE = dfs_pkg::POP_SIZE_DEF,
    parameter int CNT_W    = $clog2(POP_SIZE + 1)
) (
    input  logic                                i_clk,
    input  dfs_pkg::t_dfs_cmd                   i_cmd,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic signed [dfs_pkg::KEY_W-1:0]    i_key,
    input  logic        [dfs_pkg::TAG_W-1:0]    i_tag,
    output logic signed [dfs_pkg::KEY_W-1:0]    o_head_key,
    output logic        [dfs_pkg::TAG_W-1:0]    o_head_tag
);
    import dfs_pkg::*;

    logic signed [KEY_W-1:0] r_key [POP_SIZE];
    logic        [TAG_W-1:0] r_tag [POP_SIZE];
    logic signed [KEY_W-1:0] n_key [POP_SIZE];
    logic        [TAG_W-1:0] n_tag [POP_SIZE];

    // A cell is at or past the insert point when it is empty or holds a
    // strictly smaller key, so equal keys keep their arrival order.
    logic [POP_SIZE-1:0] w_after;

    genvar g;
    generate
        for (g = 0; g < POP_SIZE; g++) begin : g_cell
            assign w_after[g] = (CNT_W'(g) >= i_count) || (r_key[g] < i_key);

            // Next value of each cell for insert and shift.
            always_comb begin
                n_key[g] = r_key[g];
                n_tag[g] = r_tag[g];
                if (i_cmd.insert && w_after[g]) begin
                    if (g > 0 && w_after[(g > 0) ? g - 1 : 0]) begin
                        n_key[g] = r_key[(g > 0) ? g - 1 : 0];
                        n_tag[g] = r_tag[(g > 0) ? g - 1 : 0];
                    end else begin
                        n_key[g] = i_key;
                        n_tag[g] = i_tag;
                    end
                end else if (i_cmd.shift && g < POP_SIZE - 1) begin
                    n_key[g] = r_key[(g < POP_SIZE - 1) ? g + 1 : g];
                    n_tag[g] = r_tag[(g < POP_SIZE - 1) ? g + 1 : g];
                end
            end

            always_ff @(posedge i_clk) begin
                r_key[g] <= n_key[g];
                r_tag[g] <= n_tag[g];
            end
        end
    endgenerate

    // The head cell always holds the next result of a burst.
    assign o_head_key = r_key[0];
    assign o_head_tag = r_tag[0];

endmodule

// ===== rtl/dfs_ctrl.sv =====
// Controller of the descending fitness sorter: load/emit state machine,
// population size register and the item counter. Depends on dfs_pkg.
module dfs_ctrl #(
    parameter int POP_SIZE = dfs_pkg::POP_SIZE_DEF,
    parameter int CNT_W    = $clog2(POP_SIZE + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dfs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dfs_pkg::t_dfs_cmd           o_cmd,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_last
);
    import dfs_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state, n_state;
    logic [CFG_W-1:0] r_size, n_size;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] w_eff;
    logic             w_in_acc, w_out_acc;

    // Effective population size: zero acts as one, saturate at the depth.
    always_comb begin
        if (r_size == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_size > CFG_W'(POP_SIZE)) begin
            w_eff = CNT_W'(POP_SIZE);
        end else begin
            w_eff = r_size[CNT_W-1:0];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    // While emitting the counter holds the items still to go.
    assign o_count     = r_count;
    assign o_last      = (r_count == CNT_W'(1));
    assign o_cmd.insert = w_in_acc;
    assign o_cmd.shift  = w_out_acc;

    // Next state: a size write restarts the load.
    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_count = r_count;
        if (i_cfg_valid) begin
            n_size  = i_cfg_data;
            n_count = '0;
            n_state = ST_LOAD;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        n_count = r_count + CNT_W'(1);
                        if (r_count + CNT_W'(1) >= w_eff) begin
                            n_state = ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        n_count = r_count - CNT_W'(1);
                        if (o_last) begin
                            n_state = ST_LOAD;
                        end
                    end
                end
                default: n_state = ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_size  <= CFG_RESET;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/descending_fitness_sort.sv =====
// Top level of the descending fitness sorter.
// Joins the controller (dfs_ctrl) and the cell chain (dfs_chain); uses dfs_pkg.
//
// Usage:
//   Write the population size (1..POP_SIZE; 0 acts as 1, larger values
//   saturate) on the configuration channel while the block is idle; the
//   write also restarts any load in progress. Reset sets the size to 64,
//   empties the population and enters the load phase.
//   Items then enter on the input channel, one per cycle. Each is placed in
//   its sorted position of a register chain as it arrives, so no sort pass
//   follows the load.
//   In the cycle after the final item of the population is taken, the
//   sorted burst starts on the output channel: largest key first, equal
//   keys in arrival order, last_item set on the final result. One result
//   leaves per cycle while the receiver is ready; a stall holds the current
//   result and the chain until it is taken.
//   The input channel is not ready during the burst. The chain does one
//   insert or one shift at a time, never both, so loading and emitting
//   do not overlap.
module descending_fitness_sort #(
    parameter int POP_SIZE = dfs_pkg::POP_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dfs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dfs_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dfs_pkg::t_out_item          o_out_item
);
    import dfs_pkg::*;

    localparam int CNT_W = $clog2(POP_SIZE + 1);

    t_dfs_cmd                w_cmd;
    logic [CNT_W-1:0]        w_count;
    logic                    w_last;
    logic signed [KEY_W-1:0] w_head_key;
    logic        [TAG_W-1:0] w_head_tag;

    dfs_ctrl #(
        .POP_SIZE (POP_SIZE),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .o_count     (w_count),
        .o_last      (w_last)
    );

    dfs_chain #(
        .POP_SIZE (POP_SIZE),
        .CNT_W    (CNT_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_count    (w_count),
        .i_key      (i_in_item.fitness),
        .i_tag      (i_in_item.individual_tag),
        .o_head_key (w_head_key),
        .o_head_tag (w_head_tag)
    );

    // The result item is the head cell plus the end-of-burst flag.
    assign o_out_item.sorted_fitness = w_head_key;
    assign o_out_item.sorted_tag     = w_head_tag;
    assign o_out_item.last_item      = w_last;

endmodule
